/* design/sib_pkg.sv */
`default_nettype none

package sib_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LIST   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_DROPPED  = 2'd1,
        STATUS_LISTED   = 2'd2,
        STATUS_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LIST = 1'b1
    } state_t;

    typedef struct packed {
        logic               command;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] element;
        logic               last;
    } res_t;

    typedef struct packed {
        logic insert;
        logic rotate;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* design/sib_if.sv */
`default_nettype none

interface sib_req_if;
    logic          valid;
    logic          ready;
    sib_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sib_res_if;
    logic          valid;
    logic          ready;
    sib_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/sib_cell.sv */
`default_nettype none

module sib_cell (
    input  wire logic                clk,
    input  wire sib_pkg::cell_ctrl_t ctrl,
    input  wire logic                occupied,
    input  wire logic signed [31:0]  key,
    input  wire logic                left_take,
    input  wire logic signed [31:0]  left_value,
    input  wire logic signed [31:0]  right_value,
    output logic                     take,
    output logic signed [31:0]       value
);
    import sib_pkg::*;

    logic signed [31:0] value_reg;

    // take: this slot sits at or above the insertion point
    assign take  = !occupied || (value_reg >= key);
    assign value = value_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.rotate)
        begin
            value_reg <= right_value;
        end
        else if (ctrl.insert)
        begin
            if (left_take)
            begin
                value_reg <= left_value;
            end
            else if (take)
            begin
                value_reg <= key;
            end
        end
    end

endmodule

`default_nettype wire

/* design/sorted_insertion_buffer.sv */
`default_nettype none

// Sorted store of up to CAPACITY signed 32-bit values held in a ring of
// compare-and-shift cells. An insert request is taken and its status result
// is offered from the next cycle; the cells compare against the new value in
// parallel and those not below it shift up a slot, unless the store is full
// and the insert is dropped. Once a list request is taken, the ring rotates
// through cell 0 one slot a cycle until every slot has passed (so the ring
// comes back in order) before the next request can be taken; the first
// stored-count slots to pass each give one element, and output back-pressure
// holds the rotation while an element is pending. No request is taken during
// a listing. A list on an empty store gives a single empty status from the
// next cycle. A pending result that is not taken holds off the next request.
module sorted_insertion_buffer (
    input  wire logic clk,
    input  wire logic rst_n,
    sib_req_if.sink   req,
    sib_res_if.source res
);
    import sib_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_data_reg, out_data_next;

    logic              slot_free;
    logic              accept;
    logic              emit;
    logic              load;
    cell_ctrl_t        ctrl;

    logic              take  [CAPACITY];
    logic signed [31:0] value [CAPACITY];

    assign slot_free = !out_valid_reg || res.ready;
    assign req.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;
    assign emit      = {{(CNT_W-IDX_W){1'b0}}, idx_reg} < count_reg;

    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            sib_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (count_reg > CNT_W'(g)),
                .key         (req.data.value),
                .left_take   ((g == 0) ? 1'b0 : take[(g + CAPACITY - 1) % CAPACITY]),
                .left_value  (value[(g + CAPACITY - 1) % CAPACITY]),
                .right_value (value[(g + 1) % CAPACITY]),
                .take        (take[g]),
                .value       (value[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_data_next  = out_data_reg;
        load           = 1'b0;
        ctrl.insert    = 1'b0;
        ctrl.rotate    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.data.command == CMD_INSERT)
                    begin
                        load          = 1'b1;
                        out_data_next = '{STATUS_DROPPED, 32'sd0, 1'b1};
                        if (count_reg < CNT_W'(CAPACITY))
                        begin
                            ctrl.insert            = 1'b1;
                            count_next             = count_reg + 1'b1;
                            out_data_next.status   = STATUS_INSERTED;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        load          = 1'b1;
                        out_data_next = '{STATUS_EMPTY, 32'sd0, 1'b1};
                    end
                    else
                    begin
                        state_next = ST_LIST;
                        idx_next   = '0;
                    end
                end
            end
            ST_LIST:
            begin
                if (!emit || slot_free)
                begin
                    ctrl.rotate = 1'b1;
                    idx_next    = idx_reg + 1'b1;
                    if (emit)
                    begin
                        load          = 1'b1;
                        out_data_next = '{STATUS_LISTED, value[0],
                            ({{(CNT_W-IDX_W){1'b0}}, idx_reg} + 1'b1) == count_reg};
                    end
                    if (idx_reg == IDX_W'(CAPACITY - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = load || (out_valid_reg && !res.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("stored count above capacity");

    a_list_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |=> $stable(count_reg))
        else $error("count changed during listing");

    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (load && out_valid_reg) |-> res.ready)
        else $error("result overwritten while pending");

    a_no_request_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |-> !accept && !ctrl.insert)
        else $error("request taken during listing");

endmodule

`default_nettype wire
